// File: src/tlt_pkg.sv
// ----------------------------------------------------------------------------
// tlt_pkg
// Shared types, constants and helper functions for the tilt lean tracker.
// ----------------------------------------------------------------------------
package tlt_pkg;

    localparam int CAL_SAMPLES_DEF  = 200;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int CNT_W  = 5;   // step counter, covers the CORDIC steps
    localparam int DIV_W  = 24;  // divider dividend width
    localparam int CRD_W  = 27;  // CORDIC x/y width
    localparam int ANG_W  = 24;  // CORDIC angle accumulator, 2^-14 degree

    localparam int ANG_MAX   = 11520;
    localparam int DEAD_ZONE = 64;
    localparam int IIR_GAIN  = 38;
    localparam int QUARTER   = 90 * 16384;

    // Gravity band in squared raw units: moving when mag2 < MAG_LO or mag2 > MAG_HI
    localparam longint MAG_LO_L = (64'd866761 * 64'd65536 + 64'd9999) / 64'd10000;
    localparam longint MAG_HI_L = (64'd1062961 * 64'd65536) / 64'd10000;
    localparam logic [31:0] MAG_LO = 32'(MAG_LO_L);
    localparam logic [31:0] MAG_HI = 32'(MAG_HI_L);

    typedef struct packed {
        logic             load;
        logic             cordic_step;
        logic             post;
        logic             div_init;
        logic             div_step;
        logic             out_load;
        logic [CNT_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic need_div;
    } status_t;

    // atan(2^-i) in 2^-14 degree
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [CNT_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            5'd0:    v = 24'sd737280;
            5'd1:    v = 24'sd435242;
            5'd2:    v = 24'sd229970;
            5'd3:    v = 24'sd116736;
            5'd4:    v = 24'sd58595;
            5'd5:    v = 24'sd29326;
            5'd6:    v = 24'sd14667;
            5'd7:    v = 24'sd7334;
            5'd8:    v = 24'sd3667;
            5'd9:    v = 24'sd1833;
            5'd10:   v = 24'sd917;
            5'd11:   v = 24'sd458;
            5'd12:   v = 24'sd229;
            5'd13:   v = 24'sd115;
            5'd14:   v = 24'sd57;
            5'd15:   v = 24'sd29;
            5'd16:   v = 24'sd14;
            5'd17:   v = 24'sd7;
            5'd18:   v = 24'sd4;
            5'd19:   v = 24'sd2;
            5'd20:   v = 24'sd1;
            default: v = 24'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] clamp_ang(input logic signed [24:0] v);
        logic signed [15:0] r;
        if (v > 25'sd11520)
            r = 16'sd11520;
        else if (v < -25'sd11520)
            r = -16'sd11520;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// File: src/tlt_ctrl.sv
// ----------------------------------------------------------------------------
// tlt_ctrl
// Sequencer: CORDIC iterations, post step, offset divider, output handoff.
// ----------------------------------------------------------------------------
module tlt_ctrl #(
    parameter int CORDIC_STEPS = tlt_pkg::CORDIC_STEPS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  tlt_pkg::status_t status,
    output tlt_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CORDIC = 3'd1;
    localparam logic [2:0] S_POST   = 3'd2;
    localparam logic [2:0] S_DINIT  = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    localparam logic [tlt_pkg::CNT_W-1:0] STEP_LAST = tlt_pkg::CNT_W'(CORDIC_STEPS - 1);

    logic [2:0]                state_reg, state_next;
    logic [tlt_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.idx        = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_CORDIC;
                end
            end
            S_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                cnt_next        = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST)
                    state_next = S_POST;
            end
            S_POST:
            begin
                cmd.post   = 1'b1;
                state_next = status.need_div ? S_DINIT : S_FIN;
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/tlt_dp.sv
// ----------------------------------------------------------------------------
// tlt_dp
// Datapath: magnitude test, CORDIC atan2, dead zone, IIR filter, calibration.
// ----------------------------------------------------------------------------
module tlt_dp #(
    parameter int CAL_SAMPLES = tlt_pkg::CAL_SAMPLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic                op,
    input  logic signed [15:0]  accel_x,
    input  logic signed [15:0]  accel_y,
    input  logic signed [15:0]  accel_z,
    input  tlt_pkg::cmd_t       cmd,
    output tlt_pkg::status_t    status,
    output logic signed [15:0]  lean_now,
    output logic signed [14:0]  lean_smoothed,
    output logic                moving,
    output logic                calib_done
);

    localparam int W = tlt_pkg::CRD_W;
    localparam int A = tlt_pkg::ANG_W;
    localparam int D = tlt_pkg::DIV_W;
    localparam logic [9:0]   CAL_N    = 10'(CAL_SAMPLES);
    localparam logic [D-1:0] CAL_HALF = D'(CAL_SAMPLES / 2);
    // exact reciprocal for any D-bit dividend: floor(n / N) = (n * M) >> SH
    localparam int           DIV_SH   = D + $clog2(CAL_SAMPLES);
    localparam logic [D+1:0] DIV_M    =
        (D + 2)'(((64'd1 << DIV_SH) + 64'(CAL_SAMPLES - 1)) / 64'(CAL_SAMPLES));

    // configuration and persistent state
    logic                present_reg;
    logic signed [15:0]  smooth_reg, smooth_next;
    logic signed [15:0]  offset_reg, offset_next;
    logic signed [23:0]  sum_reg, sum_next;
    logic [8:0]          count_reg, count_next;

    // per-transaction working registers
    logic                op_reg;
    logic signed [15:0]  ax_reg, ay_reg, az_reg;
    logic                zero_reg;
    logic signed [W-1:0] cx_reg, cy_reg;
    logic signed [A-1:0] z_reg;
    logic [31:0]         mag_reg;
    logic signed [15:0]  raw_reg;
    logic                neg_reg;
    logic [D-1:0]        dvd_reg;

    // output registers
    logic signed [15:0]  lean_now_reg;
    logic signed [14:0]  lean_smoothed_reg;
    logic                moving_reg, done_reg;

    logic signed [W-1:0] cx0, cy0;
    logic signed [A-1:0] z0;
    logic signed [15:0]  sq_sel;
    logic signed [31:0]  sq;
    logic signed [A:0]   z_rnd;
    logic [9:0]          count_inc;
    logic signed [23:0]  sum_add;
    logic [2*D+1:0]      div_prod;
    logic signed [16:0]  lean_u;
    logic signed [17:0]  diff;
    logic signed [23:0]  scaled;
    logic signed [24:0]  s_new;
    logic signed [24:0]  avg;
    logic signed [15:0]  lean_out, smooth_out;
    logic                moving_out, done_out;

    assign count_inc = {1'b0, count_reg} + 10'd1;
    assign sum_add   = sum_reg + 24'(raw_reg);
    assign status.need_div = op_reg && present_reg && (count_inc >= CAL_N);

    // quadrant pre-rotation so that x is non-negative
    always_comb
    begin
        cx0 = W'(accel_y) <<< 8;
        cy0 = W'(accel_x) <<< 8;
        z0  = '0;
        if (accel_y < 0)
        begin
            if (accel_x >= 0)
            begin
                cx0 = W'(accel_x) <<< 8;
                cy0 = -(W'(accel_y) <<< 8);
                z0  = A'(tlt_pkg::QUARTER);
            end
            else
            begin
                cx0 = -(W'(accel_x) <<< 8);
                cy0 = W'(accel_y) <<< 8;
                z0  = -A'(tlt_pkg::QUARTER);
            end
        end
    end

    always_comb
    begin
        case (cmd.idx)
            5'd0:    sq_sel = ax_reg;
            5'd1:    sq_sel = ay_reg;
            default: sq_sel = az_reg;
        endcase
    end
    assign sq = sq_sel * sq_sel;

    assign z_rnd    = (A + 1)'(z_reg) + (A + 1)'(128);
    assign div_prod = (2 * D + 2)'(dvd_reg) * (2 * D + 2)'(DIV_M);

    // final commit of the transaction
    always_comb
    begin
        lean_u      = 17'(raw_reg) - 17'(offset_reg);
        if (lean_u > -17'sd64 && lean_u < 17'sd64)
            lean_u = '0;
        diff        = 18'(lean_u) - 18'(smooth_reg);
        scaled      = (24'(diff) * 24'sd38 + 24'sd128) >>> 8;
        s_new       = 25'(smooth_reg) + 25'(scaled);
        avg         = neg_reg ? -25'($signed({1'b0, dvd_reg})) : 25'($signed({1'b0, dvd_reg}));
        smooth_next = smooth_reg;
        offset_next = offset_reg;
        sum_next    = sum_reg;
        count_next  = count_reg;
        lean_out    = '0;
        moving_out  = 1'b0;
        done_out    = 1'b0;
        if (!op_reg)
        begin
            if (!present_reg)
                smooth_next = '0;
            else
            begin
                lean_out    = lean_u[15:0];
                smooth_next = tlt_pkg::clamp_ang(s_new);
                moving_out  = (mag_reg < tlt_pkg::MAG_LO) || (mag_reg > tlt_pkg::MAG_HI);
            end
        end
        else
        begin
            if (!present_reg)
            begin
                offset_next = '0;
                sum_next    = '0;
                count_next  = '0;
            end
            else
            begin
                lean_out = raw_reg;
                if (status.need_div)
                begin
                    offset_next = tlt_pkg::clamp_ang(avg);
                    smooth_next = '0;
                    sum_next    = '0;
                    count_next  = '0;
                    done_out    = 1'b1;
                end
                else
                begin
                    sum_next   = sum_add;
                    count_next = count_inc[8:0];
                end
            end
        end
        smooth_out = smooth_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= 1'b1;
            smooth_reg  <= '0;
            offset_reg  <= '0;
            sum_reg     <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
                present_reg <= cfg_wdata;
            if (cmd.out_load)
            begin
                smooth_reg <= smooth_next;
                offset_reg <= offset_next;
                sum_reg    <= sum_next;
                count_reg  <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            ax_reg   <= accel_x;
            ay_reg   <= accel_y;
            az_reg   <= accel_z;
            zero_reg <= (accel_x == 16'sd0) && (accel_y == 16'sd0);
            cx_reg   <= cx0;
            cy_reg   <= cy0;
            z_reg    <= z0;
            mag_reg  <= '0;
        end
        if (cmd.cordic_step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + (cy_reg >>> cmd.idx);
                cy_reg <= cy_reg - (cx_reg >>> cmd.idx);
                z_reg  <= z_reg + tlt_pkg::atan_entry(cmd.idx);
            end
            else
            begin
                cx_reg <= cx_reg - (cy_reg >>> cmd.idx);
                cy_reg <= cy_reg + (cx_reg >>> cmd.idx);
                z_reg  <= z_reg - tlt_pkg::atan_entry(cmd.idx);
            end
            if (cmd.idx < 5'd3)
                mag_reg <= mag_reg + 32'(sq);
        end
        if (cmd.post)
            raw_reg <= zero_reg ? 16'sd0 : tlt_pkg::clamp_ang(25'(z_rnd >>> 8));
        if (cmd.div_init)
        begin
            neg_reg <= sum_add < 0;
            dvd_reg <= ((sum_add < 0) ? D'(-sum_add) : D'(sum_add)) + CAL_HALF;
        end
        // quotient by reciprocal multiply, magnitude rounded half away from zero
        if (cmd.div_step)
            dvd_reg <= D'(div_prod >> DIV_SH);
        if (cmd.out_load)
        begin
            lean_now_reg      <= lean_out;
            lean_smoothed_reg <= smooth_out[14:0];
            moving_reg        <= moving_out;
            done_reg          <= done_out;
        end
    end

    assign lean_now      = lean_now_reg;
    assign lean_smoothed = lean_smoothed_reg;
    assign moving        = moving_reg;
    assign calib_done    = done_reg;

endmodule

// File: src/tilt_lean_tracker_unit.sv
// ----------------------------------------------------------------------------
// tilt_lean_tracker_unit
// Lean angle from an accelerometer sample with dead zone, IIR smoothing and
// offset calibration.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_stall): op, accel_x/y/z in signed Q8.8.
//    op 0 is a lean update, op 1 a calibration sample.
//  - Output channel (out_valid/out_stall): one transaction per input:
//    lean_now, lean_smoothed, moving, calib_done.
//  - cfg_we/cfg_wdata write sensor_present; write only while idle.
//  - After accept: the CORDIC iterations, the post step, then the output
//    load; a calibration sample that closes the average adds the offset
//    divide (setup, then one reciprocal multiply) before the output load.
//  - A new sample is taken only once the sequencer is back in idle, as the
//    single CORDIC iteration stage is shared (in_stall is high meanwhile).
//  - A finished result sits in the output register; the next sample is taken
//    meanwhile, and it waits at the final step while out_stall holds.
//  - Reset clears filter, offset and calibration sum/count, sets
//    sensor_present to 1 and empties the output register.
// ----------------------------------------------------------------------------
module tilt_lean_tracker_unit #(
    parameter int CAL_SAMPLES  = tlt_pkg::CAL_SAMPLES_DEF,
    parameter int CORDIC_STEPS = tlt_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] lean_now,
    output logic signed [14:0] lean_smoothed,
    output logic               moving,
    output logic               calib_done
);

    tlt_pkg::cmd_t    cmd;
    tlt_pkg::status_t status;

    // sequencer: owns handshakes and step counts
    tlt_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: all arithmetic, state and output payload
    tlt_dp #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .op            (op),
        .accel_x       (accel_x),
        .accel_y       (accel_y),
        .accel_z       (accel_z),
        .cmd           (cmd),
        .status        (status),
        .lean_now      (lean_now),
        .lean_smoothed (lean_smoothed),
        .moving        (moving),
        .calib_done    (calib_done)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt lean tracker: drives accelerometer
// samples, predicts lean, smoothing, motion and calibration results and
// compares every output transaction against the predicted queue.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_CAL   = tlt_pkg::CAL_SAMPLES_DEF;
    localparam int N_STEPS = tlt_pkg::CORDIC_STEPS_DEF;
    // settle wait after the last result is in, with margin
    localparam int SETTLE  = 120;

    typedef struct packed {
        logic signed [15:0] lean_now;
        logic signed [14:0] lean_smoothed;
        logic               moving;
        logic               calib_done;
    } lean_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = 1'b0;
    logic signed [15:0] accel_x = '0;
    logic signed [15:0] accel_y = '0;
    logic signed [15:0] accel_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [15:0] lean_now;
    logic signed [14:0] lean_smoothed;
    logic moving;
    logic calib_done;

    tilt_lean_tracker_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .lean_now(lean_now), .lean_smoothed(lean_smoothed),
        .moving(moving), .calib_done(calib_done)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    logic        m_present;
    int          m_smooth;
    int          m_offset;
    int          m_csum;
    int          m_ccount;
    lean_res_t   lean_q[$];
    int          n_errors = 0;
    int          n_results = 0;
    int          n_sent = 0;
    int          n_done = 0;
    bit          rx_idle_en = 1'b1;
    bit          tx_idle_en = 1'b1;
    int          rx_hold = 0;

    function automatic longint sra(longint v, int k);
        return v >>> k;
    endfunction

    function automatic int sat_ang(longint v);
        if (v > 11520)
            return 11520;
        if (v < -11520)
            return -11520;
        return int'(v);
    endfunction

    function automatic int atan_step(int i);
        int t[24] = '{737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
                      3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};
        return t[i];
    endfunction

    // atan2(num, den) in 1/64 degree via the same vectoring CORDIC
    function automatic int tilt_angle(int num, int den);
        longint cx, cy, z, t, dx, dy;
        cx = longint'(den) * 256;
        cy = longint'(num) * 256;
        z = 0;
        if (num == 0 && den == 0)
            return 0;
        if (cx < 0)
        begin
            if (cy >= 0)
            begin
                t = cx; cx = cy; cy = -t; z = 90 * 16384;
            end
            else
            begin
                t = cx; cx = -cy; cy = t; z = -90 * 16384;
            end
        end
        for (int i = 0; i < N_STEPS && i < 24; i++)
        begin
            dx = sra(cy, i);
            dy = sra(cx, i);
            if (cy > 0)
            begin
                cx += dx; cy -= dy; z += atan_step(i);
            end
            else
            begin
                cx -= dx; cy += dy; z -= atan_step(i);
            end
        end
        return sat_ang(sra(z + 128, 8));
    endfunction

    function automatic lean_res_t predict_lean(logic o, int ax, int ay, int az);
        lean_res_t r;
        int lean, avg;
        longint mag, lhs, s;
        logic mv, dn;
        lean = 0; mv = 0; dn = 0;
        if (o == 1'b0)
        begin
            if (!m_present)
                m_smooth = 0;
            else
            begin
                mag = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
                lhs = mag * 10000;
                if (lhs < (longint'(866761) << 16) || lhs > (longint'(1062961) << 16))
                    mv = 1;
                lean = tilt_angle(ax, ay) - m_offset;
                if (lean > -64 && lean < 64)
                    lean = 0;
                s = m_smooth + sra(longint'(lean - m_smooth) * 38 + 128, 8);
                m_smooth = sat_ang(s);
            end
        end
        else
        begin
            if (!m_present)
            begin
                m_offset = 0; m_csum = 0; m_ccount = 0;
            end
            else
            begin
                lean = tilt_angle(ax, ay);
                m_csum += lean;
                m_ccount++;
                if (m_ccount >= N_CAL)
                begin
                    if (m_csum >= 0)
                        avg = (m_csum + N_CAL / 2) / N_CAL;
                    else
                        avg = -((-m_csum + N_CAL / 2) / N_CAL);
                    m_offset = sat_ang(avg);
                    m_smooth = 0; m_csum = 0; m_ccount = 0;
                    dn = 1;
                end
            end
        end
        r.lean_now = lean[15:0];
        r.lean_smoothed = m_smooth[14:0];
        r.moving = mv;
        r.calib_done = dn;
        return r;
    endfunction

    // one input transaction; prediction made at acceptance order.
    // Ends at the accepting edge; valid stays up until the next drive or a drain.
    task automatic send_sample(logic o, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int gap;
        @(negedge clk);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op <= o; accel_x <= x; accel_y <= y; accel_z <= z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        lean_q.push_back(predict_lean(o, $signed(x), $signed(y), $signed(z)));
        n_sent++;
    endtask

    task automatic drain_wait();
        @(negedge clk);
        in_valid <= 1'b0;
        while (lean_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_present(logic v);
        drain_wait();
        cfg_wdata <= v; cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        m_present = v;
    endtask

    // sample with random x and y in -2500..2500 and a random z
    task automatic send_gravity(logic o);
        int x, y;
        x = $urandom_range(0, 5000) - 2500;
        y = $urandom_range(0, 5000) - 2500;
        send_sample(o, x[15:0], y[15:0], 16'($urandom_range(0, 65535)));
    endtask

    task automatic test_extremes();
        send_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);   // zero vector
        send_sample(1'b0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(1'b0, 16'h8000, 16'h8000, 16'h8000);
        send_sample(1'b0, 16'h8000, 16'h7FFF, 16'h0000);
        send_sample(1'b0, 16'h7FFF, 16'h8000, 16'h0000);
        send_sample(1'b0, 16'h0000, 16'h8000, 16'h0000);   // 180 degrees
        send_sample(1'b0, 16'h0001, 16'hFFFF, 16'h0000);
        send_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_sample(1'b0, 16'h0000, 16'd2511, 16'h0000);   // 1 g, still
        send_sample(1'b0, 16'd10, 16'd2500, 16'h0000);     // inside dead zone
        send_sample(1'b0, 16'h0000, 16'd2383, 16'h0000);   // band edges
        send_sample(1'b0, 16'h0000, 16'd2640, 16'h0000);
        send_sample(1'b1, 16'd500, 16'd2400, 16'd100);     // calibration sample
        send_sample(1'b0, 16'hFFFF, 16'h0001, 16'h0000);
    endtask

    task automatic test_calibration();
        // full average, then updates that see the offset
        for (int i = 0; i < N_CAL; i++)
        begin
            send_gravity(1'b1);
            if (i % 37 == 5)
                send_gravity(1'b0);   // interleaved update
        end
        repeat (20) send_gravity(1'b0);
        // second full average, from samples with x >= 0 and y < 0
        for (int i = 0; i < N_CAL; i++)
            send_sample(1'b1, 16'($urandom_range(0, 2000)), 16'(-$urandom_range(1, 2000)),
                        16'h0);
        repeat (10) send_gravity(1'b0);
    endtask

    task automatic test_absent();
        write_present(1'b0);
        repeat (6) send_sample(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                               16'($urandom));
        write_present(1'b1);
        repeat (10) send_gravity(1'b0);
        // partial calibration then absent wipes the count
        repeat (30) send_gravity(1'b1);
        write_present(1'b0);
        send_sample(1'b1, 16'd100, 16'd100, 16'd0);
        write_present(1'b1);
    endtask

    task automatic test_backpressure();
        // receiver holds off for a long stretch; input must stall
        rx_idle_en = 1'b0;
        rx_hold = 300;
        repeat (12) send_gravity(1'b0);
        rx_idle_en = 1'b1;
        drain_wait();   // sender pauses until all results are in
    endtask

    task automatic test_random();
        for (int i = 0; i < 500; i++)
        begin
            if (i == 400)
            begin
                rx_idle_en = 1'b0;
                tx_idle_en = 1'b0;
            end
            case ($urandom_range(0, 9))
                0, 1: send_sample(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                                  16'($urandom));
                2: send_gravity(1'b1);
                default: send_gravity(1'b0);
            endcase
        end
    endtask

    // receiver stall generator
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_stall <= 1'b1;
            rx_hold <= rx_hold - 1;
        end
        else if (rx_idle_en && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            rx_hold <= $urandom_range(0, 9);
        end
        else
            out_stall <= 1'b0;
    end

    // result checker
    always @(posedge clk)
    begin
        lean_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            n_results++;
            if (lean_q.size() == 0)
            begin
                $error("unexpected result transaction");
                n_errors++;
            end
            else
            begin
                e = lean_q.pop_front();
                if (calib_done) n_done++;
                if (lean_now !== e.lean_now)
                begin
                    $error("lean_now exp %0d got %0d", e.lean_now, lean_now);
                    n_errors++;
                end
                if (lean_smoothed !== e.lean_smoothed)
                begin
                    $error("lean_smoothed exp %0d got %0d", e.lean_smoothed, lean_smoothed);
                    n_errors++;
                end
                if (moving !== e.moving)
                begin
                    $error("moving exp %0d got %0d", e.moving, moving);
                    n_errors++;
                end
                if (calib_done !== e.calib_done)
                begin
                    $error("calib_done exp %0d got %0d", e.calib_done, calib_done);
                    n_errors++;
                end
            end
        end
    end

    initial
    begin
        m_present = 1'b1; m_smooth = 0; m_offset = 0; m_csum = 0; m_ccount = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        test_absent();
        test_calibration();
        test_backpressure();
        test_random();
        drain_wait();
        if (lean_q.size() != 0)
        begin
            $error("%0d results never arrived", lean_q.size());
            n_errors++;
        end
        $display("Sent %0d samples, checked %0d results, %0d calibrations closed,",
                 n_sent, n_results, n_done);
        $display("sensor present and absent, long output hold-off included.");
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: tilt_lean_tracker_unit.f
src/tlt_pkg.sv
src/tlt_ctrl.sv
src/tlt_dp.sv
src/tilt_lean_tracker_unit.sv
tb/tb_top.sv
